// ===== design/log_bucket_strict_priority_scheduler_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the log bucket strict priority scheduler
// Simulation builds expand them into concurrent checks; synthesis drops them.
// ----------------------------------------------------------------------------
`ifndef LOG_BUCKET_STRICT_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define LOG_BUCKET_STRICT_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle
`define LBSP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbsp check failed");
// Check that the consequent holds in the cycle after the antecedent
`define LBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbsp check failed");
`else
`define LBSP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/lbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbsp_pkg
// Shared widths, register codes, controller states and command/status types.
// ----------------------------------------------------------------------------
package lbsp_pkg;

  localparam int LEN_W     = 14;
  localparam int TAG_W     = 32;
  localparam int SCALE_W   = 16;
  localparam int PCNT_W    = 5;
  localparam int HELD_O_W  = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int EXP_W     = 4;
  localparam int FRAC_W    = 8;
  localparam int MANT_W    = 16;
  localparam int LOG_W     = EXP_W + FRAC_W;
  localparam int PROD_W    = LOG_W + SCALE_W;
  localparam int BKT_SHIFT = 22;
  localparam int BKT_W     = PROD_W - BKT_SHIFT;
  localparam int LOG_CNT_W = 4;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd17642;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SCALE   = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_DIV,
    ST_SWEEP,
    ST_IDLE,
    ST_PICK,
    ST_SEND,
    ST_REQ_GO,
    ST_REQ_LOG,
    ST_REQ_CHK,
    ST_REQ_WR,
    ST_ARR,
    ST_ARR_LOG,
    ST_ARR_WR,
    ST_FIN
  } lbsp_state_t;

  typedef struct packed {
    logic div_start;
    logic div_step;
    logic sweep_step;
    logic take_in;
    logic cfg_wr;
    logic pick;
    logic send;
    logic log_start;
    logic log_src_len;
    logic req_chk;
    logic req_wr;
    logic arr_wr;
    logic out_load;
  } lbsp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic sweep_last;
    logic can_send;
    logic more_left;
    logic log_done;
    logic arrival;
    logic out_free;
  } lbsp_status_t;

endpackage

// ===== design/lbsp_log2.sv =====
// ----------------------------------------------------------------------------
// lbsp_log2
// Iterative fixed-point log2 (Q8) by repeated squaring, then bucket scaling.
// ----------------------------------------------------------------------------
module lbsp_log2 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [lbsp_pkg::LEN_W-1:0]    value,
  input  logic [lbsp_pkg::SCALE_W-1:0]  scale,
  output logic                          done,
  output logic [lbsp_pkg::BKT_W-1:0]    bucket
);
  import lbsp_pkg::*;

  localparam logic [LOG_CNT_W-1:0] LAST_SQ = LOG_CNT_W'(FRAC_W);
  localparam logic [LOG_CNT_W-1:0] LAST_MUL = LOG_CNT_W'(FRAC_W + 1);

  logic                  busy_r;
  logic [LOG_CNT_W-1:0]  cnt_r;
  logic [EXP_W-1:0]      exp_r;
  logic [MANT_W-1:0]     mant_r;
  logic [FRAC_W-1:0]     frac_r;
  logic [PROD_W-1:0]     prod_r;
  logic [EXP_W-1:0]      exp_in;
  logic [MANT_W-1:0]     mant_in;
  logic [2*MANT_W-1:0]   sq;
  logic [MANT_W:0]       sq_top;

  // Find the top set bit and normalise it to the mantissa MSB
  always_comb begin
    exp_in = '0;
    for (int i = 1; i < LEN_W; i++) begin
      if (value[i]) exp_in = EXP_W'(i);
    end
    mant_in = MANT_W'({{(MANT_W-LEN_W){1'b0}}, value} << (EXP_W'(MANT_W-1) - exp_in));
  end

  assign sq     = mant_r * mant_r;
  assign sq_top = sq[2*MANT_W-1:MANT_W-1];
  assign done   = busy_r && (cnt_r == LAST_MUL);
  assign bucket = prod_r[PROD_W-1:BKT_SHIFT];

  // Sequence: one square per cycle, then one scaling multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (done) busy_r <= 1'b0;
      else      cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      exp_r  <= exp_in;
      mant_r <= mant_in;
      frac_r <= '0;
    end else if (busy_r && cnt_r < LAST_SQ) begin
      frac_r <= {frac_r[FRAC_W-2:0], sq_top[MANT_W]};
      mant_r <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
    end else if (busy_r && cnt_r == LAST_SQ) begin
      prod_r <= PROD_W'({exp_r, frac_r}) * PROD_W'(scale);
    end
  end

endmodule

// ===== design/lbsp_dp.sv =====
// ----------------------------------------------------------------------------
// lbsp_dp
// Datapath: FIFO descriptors, slot memory, pool split, tick arithmetic.
// ----------------------------------------------------------------------------
module lbsp_dp #(
  parameter int TOTAL_SLOT_COUNT = 128,
  parameter int MAX_QUEUES       = 16,
  parameter int PACKET_UNITS     = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lbsp_pkg::lbsp_cmd_t               cmd,
  output lbsp_pkg::lbsp_status_t            st,
  input  logic                              in_op,
  input  logic [lbsp_pkg::LEN_W-1:0]        in_msg_length,
  input  logic [lbsp_pkg::TAG_W-1:0]        in_msg_tag,
  input  logic [lbsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbsp_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_sent_valid,
  output logic [lbsp_pkg::TAG_W-1:0]        out_sent_tag,
  output logic [lbsp_pkg::LEN_W-1:0]        out_sent_remaining,
  output logic                              out_message_done,
  output logic                              out_arrival_accepted,
  output logic                              out_arrival_rejected,
  output logic [lbsp_pkg::HELD_O_W-1:0]     out_held_messages
);
  import lbsp_pkg::*;

  localparam int FW  = $clog2(TOTAL_SLOT_COUNT + 1);
  localparam int SW  = $clog2(TOTAL_SLOT_COUNT);
  localparam int QW  = $clog2(MAX_QUEUES);
  localparam int CW  = $clog2(MAX_QUEUES + 1);
  localparam int GW  = $clog2(PACKET_UNITS + 1);
  localparam int DCW = $clog2(FW);
  localparam int XW  = FW + QW;
  localparam int XB  = BKT_W + CW;
  localparam int XN  = PCNT_W + CW;
  localparam int SLOT_W = TAG_W + LEN_W;
  localparam logic [FW-1:0] TOT = FW'(TOTAL_SLOT_COUNT);
  localparam logic [CW-1:0] PCNT_RST = CW'(MAX_QUEUES < 16 ? MAX_QUEUES : 16);
  localparam logic [CW-1:0] PCNT_MAX = CW'(MAX_QUEUES);
  localparam logic [LEN_W-1:0] PU_LEN = LEN_W'(PACKET_UNITS);
  localparam logic [GW-1:0] PU_GAP = GW'(PACKET_UNITS);

  // Control registers
  logic [CW-1:0]       pcount_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [GW-1:0]       gap_r;
  logic [FW-1:0]       held_r;
  logic                out_valid_r;
  logic [DCW-1:0]      dcnt_r;
  logic [QW-1:0]       swp_r;

  // Descriptors and payload
  logic [SW-1:0]       head_r [MAX_QUEUES];
  logic [FW-1:0]       fill_r [MAX_QUEUES];
  logic [FW-1:0]       base_r [MAX_QUEUES];
  logic [FW-1:0]       cap_r  [MAX_QUEUES];
  logic [SLOT_W-1:0]   mem    [TOTAL_SLOT_COUNT];
  logic [SLOT_W-1:0]   rd_r;
  logic [FW-1:0]       div_r;
  logic [FW-1:0]       quo_r;
  logic [FW-1:0]       acc_r;
  logic [QW-1:0]       q_r;
  logic [QW-1:0]       tgt_r;
  logic                op_r;
  logic [LEN_W-1:0]    len_r;
  logic [TAG_W-1:0]    tag_r;
  logic                sent_r;
  logic [TAG_W-1:0]    stag_r;
  logic [LEN_W-1:0]    srem_r;
  logic                done_r;
  logic                acc_flag_r;
  logic                rej_r;
  logic                o_sent_r;
  logic [TAG_W-1:0]    o_tag_r;
  logic [LEN_W-1:0]    o_rem_r;
  logic                o_done_r;
  logic                o_acc_r;
  logic                o_rej_r;
  logic [HELD_O_W-1:0] o_held_r;

  // Combinational
  logic [QW-1:0]       pq;
  logic                found;
  logic [QW-1:0]       idx;
  logic [QW-1:0]       bclamp;
  logic [BKT_W-1:0]    bkt;
  logic                log_done;
  logic [SW-1:0]       head_i;
  logic [FW-1:0]       fill_i;
  logic [FW-1:0]       base_i;
  logic [FW-1:0]       cap_i;
  logic [FW-1:0]       head_ext;
  logic [FW-1:0]       head_inc;
  logic [FW-1:0]       head_dec;
  logic [FW-1:0]       off_sum;
  logic [FW-1:0]       off_wrap;
  logic                has_room;
  logic [FW:0]         div_shift;
  logic                div_ge;
  logic [FW-1:0]       sw_cap;
  logic [LEN_W-1:0]    rd_rem;
  logic [TAG_W-1:0]    rd_tag;
  logic [LEN_W-1:0]    log_val;
  logic [CW-1:0]       pc_lim;
  logic [PCNT_W-1:0]   cfg_n;
  logic [CW-1:0]       cfg_pc;

  // Pick the lowest in-use FIFO that holds an entry
  always_comb begin
    pq    = '0;
    found = 1'b0;
    for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
      if (fill_r[i] != '0 && cap_r[i] != '0 && CW'(i) < pcount_r) begin
        pq    = QW'(i);
        found = 1'b1;
      end
    end
  end

  // Clamp the bucket to the last FIFO in use
  assign pc_lim = pcount_r - 1'b1;
  assign bclamp = (XB'(bkt) > XB'(pc_lim)) ? QW'(pc_lim) : QW'(bkt);

  // Select the one FIFO that this step looks at
  always_comb begin
    if (cmd.sweep_step)  idx = swp_r;
    else if (cmd.pick)   idx = pq;
    else if (cmd.req_wr) idx = tgt_r;
    else                 idx = bclamp;
  end

  assign head_i   = head_r[idx];
  assign fill_i   = fill_r[idx];
  assign base_i   = base_r[idx];
  assign cap_i    = cap_r[idx];
  assign head_ext = FW'(head_i);
  assign head_inc = (head_ext + 1'b1 == cap_i) ? '0 : head_ext + 1'b1;
  assign head_dec = (head_ext == '0) ? cap_i - 1'b1 : head_ext - 1'b1;
  assign off_sum  = head_ext + fill_i;
  assign off_wrap = (off_sum >= cap_i) ? off_sum - cap_i : off_sum;
  assign has_room = fill_i < cap_i;

  // One restoring division step of the pool size by the FIFO count
  assign div_shift = {div_r, TOT[dcnt_r]};
  assign div_ge    = div_shift >= (FW+1)'(pcount_r);

  // Share for the FIFO under the sweep
  assign sw_cap = (CW'(swp_r) < pcount_r)
                ? quo_r + ((XW'(swp_r) < XW'(div_r)) ? FW'(1) : FW'(0))
                : '0;

  assign rd_rem  = rd_r[LEN_W-1:0];
  assign rd_tag  = rd_r[SLOT_W-1:LEN_W];
  assign log_val = cmd.log_src_len ? len_r : srem_r;

  // Clamp a written FIFO count into range
  assign cfg_n  = cfg_data[PCNT_W-1:0];
  assign cfg_pc = (cfg_n == '0) ? CW'(1)
                : (XN'(cfg_n) > XN'(PCNT_MAX)) ? PCNT_MAX : CW'(cfg_n);

  lbsp_log2 u_log2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.log_start),
    .value  (log_val),
    .scale  (scale_r),
    .done   (log_done),
    .bucket (bkt)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r    <= PCNT_RST;
      scale_r     <= SCALE_RST;
      gap_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      dcnt_r      <= '0;
      swp_r       <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        unique case (cfg_index)
          REG_PRIORITY_COUNT: pcount_r <= cfg_pc;
          REG_BUCKET_SCALE:   scale_r  <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.div_start) begin
        dcnt_r <= DCW'(FW - 1);
        swp_r  <= '0;
      end
      if (cmd.div_step) dcnt_r <= dcnt_r - 1'b1;
      if (cmd.sweep_step) begin
        swp_r <= swp_r + 1'b1;
        if (st.sweep_last) held_r <= '0;
      end
      // Count down the gap as the tick starts
      if (cmd.take_in && gap_r != '0) gap_r <= gap_r - 1'b1;
      if (cmd.send) begin
        if (rd_rem > PU_LEN) begin
          gap_r <= PU_GAP;
        end else begin
          gap_r  <= GW'(rd_rem);
          held_r <= held_r - 1'b1;
        end
      end
      if (cmd.arr_wr && has_room) held_r <= held_r + 1'b1;
      // Hold the result word until taken
      if (cmd.out_load)     out_valid_r <= 1'b1;
      else if (out_ready)   out_valid_r <= 1'b0;
    end
  end

  // Descriptors, tick payload and results
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_r <= '0;
      quo_r <= '0;
      acc_r <= '0;
    end
    if (cmd.div_step) begin
      div_r <= div_ge ? FW'(div_shift - (FW+1)'(pcount_r)) : FW'(div_shift);
      quo_r <= {quo_r[FW-2:0], div_ge};
    end
    if (cmd.sweep_step) begin
      cap_r[idx]  <= sw_cap;
      base_r[idx] <= acc_r;
      head_r[idx] <= '0;
      fill_r[idx] <= '0;
      acc_r       <= acc_r + sw_cap;
    end
    if (cmd.take_in) begin
      op_r       <= in_op;
      len_r      <= in_msg_length;
      tag_r      <= in_msg_tag;
      sent_r     <= 1'b0;
      stag_r     <= '0;
      srem_r     <= '0;
      done_r     <= 1'b0;
      acc_flag_r <= 1'b0;
      rej_r      <= 1'b0;
    end
    // Pop the head of the chosen FIFO
    if (cmd.pick && st.can_send) begin
      q_r         <= pq;
      head_r[idx] <= SW'(head_inc);
      fill_r[idx] <= fill_i - 1'b1;
    end
    if (cmd.send) begin
      sent_r <= 1'b1;
      stag_r <= rd_tag;
      if (rd_rem > PU_LEN) srem_r <= rd_rem - PU_LEN;
      else                 done_r <= 1'b1;
    end
    if (cmd.req_chk) tgt_r <= has_room ? bclamp : q_r;
    // Push the partly sent message at the front
    if (cmd.req_wr) begin
      head_r[idx] <= SW'(head_dec);
      fill_r[idx] <= fill_i + 1'b1;
    end
    // Push the arrival at the back, or drop it
    if (cmd.arr_wr) begin
      if (has_room) begin
        fill_r[idx] <= fill_i + 1'b1;
        acc_flag_r  <= 1'b1;
      end else begin
        rej_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      o_sent_r <= sent_r;
      o_tag_r  <= stag_r;
      o_rem_r  <= srem_r;
      o_done_r <= done_r;
      o_acc_r  <= acc_flag_r;
      o_rej_r  <= rej_r;
      o_held_r <= HELD_O_W'(held_r);
    end
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.req_wr) begin
      mem[SW'(base_i + head_dec)] <= {stag_r, srem_r};
    end else if (cmd.arr_wr && has_room) begin
      mem[SW'(base_i + off_wrap)] <= {tag_r, len_r};
    end
    if (cmd.pick) rd_r <= mem[SW'(base_i + head_ext)];
  end

  assign st.div_last   = (dcnt_r == '0);
  assign st.sweep_last = (swp_r == QW'(MAX_QUEUES - 1));
  assign st.can_send   = (held_r != '0) && (gap_r == '0) && found;
  assign st.more_left  = rd_rem > PU_LEN;
  assign st.log_done   = log_done;
  assign st.arrival    = op_r && (len_r != '0);
  assign st.out_free   = !out_valid_r || out_ready;

  assign out_valid            = out_valid_r;
  assign out_sent_valid       = o_sent_r;
  assign out_sent_tag         = o_tag_r;
  assign out_sent_remaining   = o_rem_r;
  assign out_message_done     = o_done_r;
  assign out_arrival_accepted = o_acc_r;
  assign out_arrival_rejected = o_rej_r;
  assign out_held_messages    = o_held_r;

endmodule

// ===== design/lbsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbsp_ctrl
// Controller: sequences pool split, packet send, requeue and arrival per tick.
// ----------------------------------------------------------------------------
module lbsp_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lbsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  lbsp_pkg::lbsp_status_t          st,
  output lbsp_pkg::lbsp_cmd_t             cmd
);
  import lbsp_pkg::*;

  lbsp_state_t state_r;
  lbsp_state_t state_nxt;
  logic        in_fire;
  logic        cfg_fire;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_INIT;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:    state_nxt = ST_DIV;
      ST_DIV:     if (st.div_last) state_nxt = ST_SWEEP;
      ST_SWEEP:   if (st.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (cfg_fire && cfg_index == REG_PRIORITY_COUNT) state_nxt = ST_INIT;
        else if (in_fire)                                 state_nxt = ST_PICK;
      end
      ST_PICK:    state_nxt = st.can_send ? ST_SEND : ST_ARR;
      ST_SEND:    state_nxt = st.more_left ? ST_REQ_GO : ST_ARR;
      ST_REQ_GO:  state_nxt = ST_REQ_LOG;
      ST_REQ_LOG: if (st.log_done) state_nxt = ST_REQ_CHK;
      ST_REQ_CHK: state_nxt = ST_REQ_WR;
      ST_REQ_WR:  state_nxt = ST_ARR;
      ST_ARR:     state_nxt = st.arrival ? ST_ARR_LOG : ST_FIN;
      ST_ARR_LOG: if (st.log_done) state_nxt = ST_ARR_WR;
      ST_ARR_WR:  state_nxt = ST_FIN;
      ST_FIN:     if (st.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_INIT;
    endcase
  end

  // Commands
  always_comb begin
    cmd         = '0;
    cmd.cfg_wr  = cfg_fire;
    cmd.take_in = in_fire;
    unique case (state_r)
      ST_INIT:    cmd.div_start  = 1'b1;
      ST_DIV:     cmd.div_step   = 1'b1;
      ST_SWEEP:   cmd.sweep_step = 1'b1;
      ST_PICK:    cmd.pick       = 1'b1;
      ST_SEND:    cmd.send       = 1'b1;
      ST_REQ_GO:  cmd.log_start  = 1'b1;
      ST_REQ_CHK: cmd.req_chk    = 1'b1;
      ST_REQ_WR:  cmd.req_wr     = 1'b1;
      ST_ARR: begin
        cmd.log_start   = st.arrival;
        cmd.log_src_len = 1'b1;
      end
      ST_ARR_WR:  cmd.arr_wr     = 1'b1;
      ST_FIN:     cmd.out_load   = st.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/log_bucket_strict_priority_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// log_bucket_strict_priority_scheduler_unit
// Strict priority scheduler over log2 length buckets sharing one slot pool.
// ----------------------------------------------------------------------------
// channel  dir  handshake            word
// in_      in   in_valid/in_ready    op, msg_length, msg_tag (one line tick)
// out_     out  out_valid/out_ready  sent and arrival outcome, held count
// cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One tick at a time: a plain tick passes PICK, ARR and FIN; a tick with a send,
// a requeue and an arrival also passes SEND, the REQ states, ARR_LOG and ARR_WR.
// Each bucket lookup runs in the iterative log2 unit (eight squarings plus
// scaling) and the slot memory read is registered. After reset and after each
// priority_count write the pool is split again (INIT, DIV, then SWEEP over
// every FIFO), input held off. A result word waiting on out_ready
// stalls only the end of the next tick.
// ----------------------------------------------------------------------------
`include "log_bucket_strict_priority_scheduler_unit_defines.svh"

module log_bucket_strict_priority_scheduler_unit #(
  parameter int TOTAL_SLOT_COUNT = 128,
  parameter int MAX_QUEUES       = 16,
  parameter int PACKET_UNITS     = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_op,
  input  logic [lbsp_pkg::LEN_W-1:0]        in_msg_length,
  input  logic [lbsp_pkg::TAG_W-1:0]        in_msg_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_sent_valid,
  output logic [lbsp_pkg::TAG_W-1:0]        out_sent_tag,
  output logic [lbsp_pkg::LEN_W-1:0]        out_sent_remaining,
  output logic                              out_message_done,
  output logic                              out_arrival_accepted,
  output logic                              out_arrival_rejected,
  output logic [lbsp_pkg::HELD_O_W-1:0]     out_held_messages,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbsp_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import lbsp_pkg::*;

  lbsp_cmd_t    cmd;
  lbsp_status_t st;

  lbsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .st        (st),
    .cmd       (cmd)
  );

  lbsp_dp #(
    .TOTAL_SLOT_COUNT (TOTAL_SLOT_COUNT),
    .MAX_QUEUES       (MAX_QUEUES),
    .PACKET_UNITS     (PACKET_UNITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .in_op                (in_op),
    .in_msg_length        (in_msg_length),
    .in_msg_tag           (in_msg_tag),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_sent_valid       (out_sent_valid),
    .out_sent_tag         (out_sent_tag),
    .out_sent_remaining   (out_sent_remaining),
    .out_message_done     (out_message_done),
    .out_arrival_accepted (out_arrival_accepted),
    .out_arrival_rejected (out_arrival_rejected),
    .out_held_messages    (out_held_messages)
  );

  // A finished message must have sent a packet
  `LBSP_ASSERT_SAME(a_done_sent, clk, rst_n, out_valid && out_message_done, out_sent_valid)
  // An arrival is never both queued and dropped
  `LBSP_ASSERT_SAME(a_arr_excl, clk, rst_n, out_valid && out_arrival_accepted, !out_arrival_rejected)
  // One tick at a time: no second word straight after an accepted one
  `LBSP_ASSERT_NEXT(a_one_tick, clk, rst_n, in_valid && in_ready, !in_ready)
  // A FIFO count write starts a pool split that holds off input
  `LBSP_ASSERT_NEXT(a_split_hold, clk, rst_n, cmd.cfg_wr && cfg_index == REG_PRIORITY_COUNT, !in_ready)

endmodule

// ===== verif/log_bucket_strict_priority_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the log bucket strict priority scheduler
// Drives line ticks (plain or with a message arrival) through the input
// channel, keeps its own model of the bucket FIFOs and gap counter, and checks
// every result word field by field. Both channels idle at random, and the
// register settings are changed between phases while the block is quiet.
// ----------------------------------------------------------------------------
module log_bucket_strict_priority_scheduler_unit_tb;
  import lbsp_pkg::*;

  localparam int SLOTS    = 128;
  localparam int QUEUES   = 16;
  localparam int PKT      = 24;
  localparam int LIMIT    = 600000;
  localparam bit OP_TICK  = 1'b0;
  localparam bit OP_ARRIVE = 1'b1;

  typedef struct packed {
    bit              sent;
    bit [TAG_W-1:0]  tag;
    bit [LEN_W-1:0]  remaining;
    bit              done;
    bit              accepted;
    bit              rejected;
    bit [7:0]        held;
  } tick_word_t;

  typedef struct packed {
    bit              op;
    bit [LEN_W-1:0]  len;
    bit [TAG_W-1:0]  tag;
    bit              typed;
    tick_word_t      word;
  } tick_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [LEN_W-1:0]      in_msg_length;
  logic [TAG_W-1:0]      in_msg_tag;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_sent_valid;
  logic [TAG_W-1:0]      out_sent_tag;
  logic [LEN_W-1:0]      out_sent_remaining;
  logic                  out_message_done;
  logic                  out_arrival_accepted;
  logic                  out_arrival_rejected;
  logic [HELD_O_W-1:0]   out_held_messages;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DAT_W-1:0]  cfg_data;

  log_bucket_strict_priority_scheduler_unit dut (.*);

  // Scheduler model state
  bit [TAG_W-1:0] slot_tag [SLOTS];
  int unsigned    slot_rem [SLOTS];
  int unsigned    q_head [QUEUES];
  int unsigned    q_fill [QUEUES];
  int unsigned    q_base [QUEUES];
  int unsigned    q_cap  [QUEUES];
  int unsigned    gap_left;
  int unsigned    held_total;
  int unsigned    prio_count;
  int unsigned    scale;

  tick_word_t expected_words[$];
  int unsigned errors, words_checked, ticks_sent, rejects_seen, packets_seen;
  int unsigned cycles;
  bit          quiet;
  int unsigned out_stall;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Split the slot pool evenly, extras to the low queues, and empty all
  function automatic void split_slots();
    int unsigned base;
    base = 0;
    for (int i = 0; i < QUEUES; i++) begin
      q_head[i] = 0;
      q_fill[i] = 0;
      q_cap[i]  = (i < prio_count) ? SLOTS / prio_count + ((i < SLOTS % prio_count) ? 1 : 0) : 0;
      q_base[i] = base;
      base += q_cap[i];
    end
    held_total = 0;
  endfunction

  // log2 with eight fraction bits by repeated squaring of a Q1.15 mantissa
  function automatic int unsigned log2_q8(int unsigned v);
    int unsigned e, m, frac;
    e = 0;
    frac = 0;
    while (e < 13 && (v >> (e + 1)) != 0) e++;
    m = (v << (15 - e)) & 32'hFFFF;
    for (int i = 0; i < 8; i++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        frac |= 1;
        m = m >> 1;
      end
    end
    return (e << 8) | frac;
  endfunction

  function automatic int unsigned bucket_for(int unsigned rem);
    int unsigned b;
    b = (log2_q8(rem) * scale) >> 22;
    return (b > prio_count - 1) ? prio_count - 1 : b;
  endfunction

  function automatic int unsigned slot_index(int unsigned q, int unsigned off);
    return (q_base[q] + (q_head[q] + off) % q_cap[q]) % SLOTS;
  endfunction

  function automatic void apply_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DAT_W-1:0] val);
    int unsigned n;
    if (idx == REG_PRIORITY_COUNT) begin
      n = val & 5'h1F;
      if (n < 1) n = 1;
      if (n > QUEUES) n = QUEUES;
      prio_count = n;
      split_slots();
    end else begin
      scale = val;
    end
  endfunction

  // Advance the model by one line tick and return the word it produces
  function automatic tick_word_t schedule_tick(bit op, bit [LEN_W-1:0] len, bit [TAG_W-1:0] tag);
    tick_word_t  w;
    int unsigned q, s, rem, b;
    w = '0;
    if (gap_left > 0) gap_left--;
    if (held_total != 0 && gap_left == 0) begin
      for (q = 0; q < prio_count; q++)
        if (q_fill[q] != 0 && q_cap[q] != 0) break;
      if (q < prio_count) begin
        s = slot_index(q, 0);
        rem = slot_rem[s];
        w.tag = slot_tag[s];
        q_head[q] = (q_head[q] + 1) % q_cap[q];
        q_fill[q]--;
        w.sent = 1'b1;
        if (rem > PKT) begin
          rem -= PKT;
          w.remaining = LEN_W'(rem);
          b = bucket_for(rem);
          // requeue at the front; fall back to the source queue when full
          if (q_fill[b] >= q_cap[b]) b = q;
          q_head[b] = (q_head[b] + q_cap[b] - 1) % q_cap[b];
          s = slot_index(b, 0);
          slot_tag[s] = w.tag;
          slot_rem[s] = rem;
          q_fill[b]++;
          gap_left = PKT;
        end else begin
          w.done = 1'b1;
          gap_left = rem;
          held_total--;
        end
      end
    end
    if (op == OP_ARRIVE && len != 0) begin
      b = bucket_for(len);
      if (q_fill[b] < q_cap[b]) begin
        s = slot_index(b, q_fill[b]);
        slot_tag[s] = tag;
        slot_rem[s] = len;
        q_fill[b]++;
        held_total++;
        w.accepted = 1'b1;
      end else begin
        w.rejected = 1'b1;
      end
    end
    w.held = 8'(held_total);
    return w;
  endfunction

  // Present one tick word and record its expected outcome on acceptance
  task automatic send_tick(input tick_row_t row);
    int unsigned gap;
    tick_word_t  w;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= row.op;
    in_msg_length <= row.len;
    in_msg_tag    <= row.tag;
    do @(posedge clk); while (!in_ready);
    w = schedule_tick(row.op, row.len, row.tag);
    expected_words.insert(expected_words.size(), row.typed ? row.word : w);
    ticks_sent++;
  endtask

  // Write one register once every expected word has come back
  task automatic write_register(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DAT_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, val);
  endtask

  // Result side: random stalls, compare each word with the oldest expectation
  always @(posedge clk) begin
    tick_word_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_sent_valid, out_sent_tag, out_sent_remaining, out_message_done,
                out_arrival_accepted, out_arrival_rejected, out_held_messages};
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %p", $time, got);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (got.rejected) rejects_seen++;
          if (got.sent) packets_seen++;
          if (got.sent != want.sent || got.tag != want.tag ||
              got.remaining != want.remaining || got.done != want.done ||
              got.accepted != want.accepted || got.rejected != want.rejected ||
              got.held != want.held) begin
            errors++;
            $display("%0t: word %0d expected %p actual %p", $time, words_checked, want, got);
          end
        end
        out_stall <= quiet ? 0 : $urandom_range(0, 5);
        out_ready <= quiet ? 1'b1 : ($urandom_range(0, 5) == 0);
      end else begin
        if (out_stall > 0) out_stall <= out_stall - 1;
        out_ready <= (out_stall <= 1);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("log_bucket_strict_priority_scheduler_unit: mismatch");
      $finish;
    end
  end

  initial begin
    tick_row_t   row;
    tick_row_t   directed[$];
    int unsigned pcount_set[8];
    int unsigned scale_set[8];
    int unsigned arrive_pct, k;
    pcount_set = '{16, 1, 0, 31, 5, 17, 8, 3};
    scale_set  = '{17642, 17642, 40000, 65535, 0, 9000, 30000, 12000};
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = 1'b0;
    in_msg_length = '0;
    in_msg_tag = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_PRIORITY_COUNT;
    cfg_data = '0;
    quiet = 1'b0;
    errors = 0;
    words_checked = 0;
    ticks_sent = 0;
    rejects_seen = 0;
    packets_seen = 0;
    prio_count = QUEUES;
    scale = SCALE_RST;
    gap_left = 0;
    split_slots();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks: idle line, a one unit message, an ignored empty arrival,
    // then extremes of length and tag, and messages just around one packet
    directed.insert(directed.size(), '{OP_TICK, 14'd0, 32'd0, 1'b1, '{0, 0, 0, 0, 0, 0, 0}});
    directed.insert(directed.size(),
                    '{OP_ARRIVE, 14'd1, 32'hA5A5_A5A5, 1'b1, '{0, 0, 0, 0, 1, 0, 1}});
    directed.insert(directed.size(),
                    '{OP_TICK, 14'd0, 32'd0, 1'b1, '{1, 32'hA5A5_A5A5, 0, 1, 0, 0, 0}});
    directed.insert(directed.size(),
                    '{OP_ARRIVE, 14'd0, 32'hFFFF_FFFF, 1'b1, '{0, 0, 0, 0, 0, 0, 0}});
    directed.insert(directed.size(), '{OP_ARRIVE, 14'd16383, 32'hFFFF_FFFF, 1'b0, '0});
    directed.insert(directed.size(), '{OP_ARRIVE, 14'd24, 32'h0000_0001, 1'b0, '0});
    directed.insert(directed.size(), '{OP_ARRIVE, 14'd25, 32'h8000_0000, 1'b0, '0});
    directed.insert(directed.size(), '{OP_ARRIVE, 14'd2, 32'h5A5A_5A5A, 1'b0, '0});
    directed.insert(directed.size(), '{OP_ARRIVE, 14'd8192, 32'h1234_5678, 1'b0, '0});
    directed.insert(directed.size(), '{OP_ARRIVE, 14'd48, 32'h0F0F_0F0F, 1'b0, '0});
    for (int i = 0; i < 14; i++)
      directed.insert(directed.size(),
                      '{(i % 3 == 0) ? OP_ARRIVE : OP_TICK, LEN_W'(3 + i * 1000),
                        TAG_W'(32'hC000_0000 + i), 1'b0, '0});
    foreach (directed[i]) send_tick(directed[i]);

    // Random phases under several register settings
    for (int p = 0; p < 8; p++) begin
      write_register(REG_PRIORITY_COUNT, CFG_DAT_W'(pcount_set[p]));
      write_register(REG_BUCKET_SCALE, CFG_DAT_W'(scale_set[p]));
      quiet = (p == 3);
      arrive_pct = 20 + 10 * p;
      for (int i = 0; i < 160; i++) begin
        // hold the line once mid phase until everything has drained
        if (p == 5 && i == 80) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_words.size() != 0) @(posedge clk);
        end
        k = $urandom_range(0, 13);
        row.op    = ($urandom_range(0, 99) < arrive_pct) ? OP_ARRIVE : OP_TICK;
        row.len   = LEN_W'($urandom_range(1 << k,
                                          (2 << k) - 1 > 16383 ? 16383 : (2 << k) - 1));
        if ($urandom_range(0, 49) == 0) row.len = $urandom_range(0, 1) ? 14'd0 : 14'd16383;
        row.tag   = $urandom;
        row.typed = 1'b0;
        row.word  = '0;
        send_tick(row);
      end
    end
    in_valid <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran %0d ticks over 8 register settings; %0d words checked, %0d packets sent,",
             ticks_sent, words_checked, packets_seen);
    $display("%0d arrivals turned away by full buckets.", rejects_seen);
    if (errors == 0) begin
      $display("log_bucket_strict_priority_scheduler_unit: match");
    end else begin
      $display("log_bucket_strict_priority_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== log_bucket_strict_priority_scheduler_unit.f =====
+incdir+design
design/lbsp_pkg.sv
design/lbsp_log2.sv
design/lbsp_dp.sv
design/lbsp_ctrl.sv
design/log_bucket_strict_priority_scheduler_unit.sv
verif/log_bucket_strict_priority_scheduler_unit_tb.sv
